>>> src/nhl_pkg.sv
// Package for the nibble handshake link: item, result and config structs,
// command codes, phase encoding and reset constants.
// No dependencies.
package nhl_pkg;

  // Command codes carried in the input tuser field
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SEND    = 3'd1,
    OP_RECEIVE = 3'd2,
    OP_TO_RECV = 3'd3,
    OP_TO_SEND = 3'd4,
    OP_REQUEST = 3'd5
  } op_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_SETTLE  = 1'b1
  } cfg_idx_e;

  localparam int unsigned TimeoutW = 24;
  localparam int unsigned SettleW  = 16;
  localparam int unsigned CfgDataW = 24;

  localparam logic [TimeoutW-1:0] TimeoutReset = 24'd2000000;
  localparam logic [SettleW-1:0]  SettleReset  = 16'd40;

  // Handshake phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE      = 9'b0_0000_0001,
    PH_SEND_LO   = 9'b0_0000_0010,
    PH_SEND_HI   = 9'b0_0000_0100,
    PH_RECV_LO   = 9'b0_0000_1000,
    PH_RECV_HI   = 9'b0_0001_0000,
    PH_SETTLE    = 9'b0_0010_0000,
    PH_TOSEND_LO = 9'b0_0100_0000,
    PH_REQ_HI    = 9'b0_1000_0000,
    PH_REQ_LO    = 9'b1_0000_0000
  } phase_e;

  typedef struct packed {
    logic [TimeoutW-1:0] timeout_ticks;
    logic [SettleW-1:0]  settle_ticks;
  } cfg_t;

  // One tick sample
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] byte_to_send;
    logic       ack_line;
    logic [3:0] data_lines;
  } item_t;

  // One result, state after the tick
  typedef struct packed {
    logic [3:0] data_drive;
    logic       drive_enable;
    logic       strobe_line;
    logic       request_line;
    logic [7:0] byte_received;
    logic       byte_valid;
    logic       op_done;
    logic       busy_res;
    logic       timeout_flag;
  } res_t;

endpackage

>>> src/nibble_handshake_link.sv
// Top level of the nibble handshake link: stream input register, config
// registers, the handshake core and the result register.
// Depends on nhl_pkg and nhl_core.
//
//  channel   | direction | contents
//  s_axis    | in        | one tick sample and optional command
//  m_axis    | out       | bus line levels and status after that tick
//  cfg       | in        | timeout_ticks (0), settle_ticks (1)
//
// One transaction in, one transaction out; a new tick is taken every cycle unless the output stalls.
// Each tick passes through the input register, then core logic into the result
// register. The core state advances only when the input register moves on.
// Reset: idle, strobe and request high, lines input, registers at defaults.
// An output stall holds the result register and backs up into the input.
module nibble_handshake_link (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [7:0] byte_to_send, [8] ack_line, [12:9] data_lines, [15:13] zero
  input  logic [15:0]                  s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]                   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [3:0] data_drive, [4] drive_enable, [5] strobe_line, [6] request_line,
  // [14:7] byte_received, [15] byte_valid, [16] op_done, [17] busy_res,
  // [18] timeout_flag, [23:19] zero
  output logic [23:0]                  m_axis_tdata_o,
  input  logic                         cfg_we_i,
  input  logic [nhl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nhl_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import nhl_pkg::*;

  logic  in_valid_q;
  item_t in_q;
  logic  out_valid_q;
  res_t  out_q;
  cfg_t  cfg_q;
  res_t  res;
  logic  advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TimeoutReset;
      cfg_q.settle_ticks  <= SettleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata_i[TimeoutW-1:0];
        CFG_SETTLE:  cfg_q.settle_ticks  <= cfg_wdata_i[SettleW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.operation    <= s_axis_tuser_i;
      in_q.byte_to_send <= s_axis_tdata_i[7:0];
      in_q.ack_line     <= s_axis_tdata_i[8];
      in_q.data_lines   <= s_axis_tdata_i[12:9];
    end
  end

  nhl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.timeout_flag, out_q.busy_res, out_q.op_done,
                            out_q.byte_valid, out_q.byte_received, out_q.request_line,
                            out_q.strobe_line, out_q.drive_enable, out_q.data_drive};

endmodule

>>> src/nhl_core.sv
// Handshake state machine of the nibble link: bus state registers and the
// per-tick next-state logic. Depends on nhl_pkg.
module nhl_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  nhl_pkg::item_t item_i,
  input  nhl_pkg::cfg_t  cfg_i,
  output nhl_pkg::res_t  res_o
);
  import nhl_pkg::*;

  phase_e              phase_q, phase_d;
  logic [TimeoutW-1:0] wait_count_q, wait_count_d;
  logic [7:0]          shift_byte_q, shift_byte_d;
  logic [7:0]          pending_q, pending_d;
  logic [3:0]          drive_nibble_q, drive_nibble_d;
  logic                drive_on_q, drive_on_d;
  logic                strobe_q, strobe_d;
  logic                request_q, request_d;

  logic                valid, done, tout;
  logic                tmo_hit;
  logic [TimeoutW-1:0] wait_inc;

  assign tmo_hit  = wait_count_q >= cfg_i.timeout_ticks;
  assign wait_inc = wait_count_q + 24'd1;

  // Next state for one tick
  always_comb begin
    phase_d        = phase_q;
    wait_count_d   = wait_count_q;
    shift_byte_d   = shift_byte_q;
    pending_d      = pending_q;
    drive_nibble_d = drive_nibble_q;
    drive_on_d     = drive_on_q;
    strobe_d       = strobe_q;
    request_d      = request_q;
    valid          = 1'b0;
    done           = 1'b0;
    tout           = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        wait_count_d = '0;
        case (item_i.operation)
          OP_SEND: begin
            pending_d = item_i.byte_to_send;
            phase_d   = PH_SEND_LO;
          end
          OP_RECEIVE: begin
            drive_on_d = 1'b0;
            strobe_d   = 1'b0;
            phase_d    = PH_RECV_LO;
          end
          OP_TO_RECV: begin
            drive_on_d = 1'b0;
            strobe_d   = 1'b1;
            phase_d    = PH_SETTLE;
          end
          OP_TO_SEND: phase_d = PH_TOSEND_LO;
          OP_REQUEST: phase_d = PH_REQ_HI;
          default: ;
        endcase
      end
      PH_SEND_LO: begin
        if (!item_i.ack_line) begin
          drive_nibble_d = pending_q[3:0];
          drive_on_d     = 1'b1;
          strobe_d       = 1'b0;
          wait_count_d   = '0;
          phase_d        = PH_SEND_HI;
        end else begin
          tout = tmo_hit;
        end
      end
      PH_SEND_HI: begin
        if (item_i.ack_line) begin
          drive_nibble_d = pending_q[7:4];
          drive_on_d     = 1'b1;
          strobe_d       = 1'b1;
          phase_d        = PH_IDLE;
          done           = 1'b1;
        end else begin
          tout = tmo_hit;
        end
      end
      PH_RECV_LO: begin
        if (!item_i.ack_line) begin
          shift_byte_d = {4'd0, item_i.data_lines};
          strobe_d     = 1'b1;
          wait_count_d = '0;
          phase_d      = PH_RECV_HI;
        end else begin
          tout = tmo_hit;
        end
      end
      PH_RECV_HI: begin
        if (item_i.ack_line) begin
          shift_byte_d = {item_i.data_lines, shift_byte_q[3:0]};
          phase_d      = PH_IDLE;
          valid        = 1'b1;
          done         = 1'b1;
        end else begin
          tout = tmo_hit;
        end
      end
      PH_SETTLE: begin
        if (wait_count_q >= {8'd0, cfg_i.settle_ticks}) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end else begin
          wait_count_d = wait_inc;
        end
      end
      PH_TOSEND_LO: begin
        if (!item_i.ack_line) begin
          drive_on_d = 1'b1;
          strobe_d   = 1'b1;
          phase_d    = PH_IDLE;
          done       = 1'b1;
        end else begin
          tout = tmo_hit;
        end
      end
      PH_REQ_HI: begin
        if (item_i.ack_line) begin
          drive_on_d = 1'b0;
          strobe_d   = 1'b1;
          request_d  = 1'b0;
          phase_d    = PH_REQ_LO;
        end
      end
      PH_REQ_LO: begin
        if (!item_i.ack_line) begin
          strobe_d   = 1'b1;
          drive_on_d = 1'b0;
          request_d  = 1'b1;
          phase_d    = PH_IDLE;
          done       = 1'b1;
        end
      end
      default: begin
        strobe_d   = 1'b1;
        drive_on_d = 1'b0;
        request_d  = 1'b1;
        phase_d    = PH_IDLE;
      end
    endcase

    // unmet timed wait: give up or count
    case (phase_q)
      PH_SEND_LO, PH_SEND_HI, PH_RECV_LO, PH_RECV_HI, PH_TOSEND_LO: begin
        if (phase_d == phase_q) begin
          if (tmo_hit) begin
            strobe_d   = 1'b1;
            drive_on_d = 1'b0;
            request_d  = 1'b1;
            phase_d    = PH_IDLE;
          end else begin
            wait_count_d = wait_inc;
          end
        end
      end
      default: ;
    endcase

    if (phase_d == PH_IDLE) wait_count_d = '0;
  end

  // Result of this tick
  always_comb begin
    res_o.data_drive    = drive_nibble_d;
    res_o.drive_enable  = drive_on_d;
    res_o.strobe_line   = strobe_d;
    res_o.request_line  = request_d;
    res_o.byte_received = valid ? shift_byte_d : 8'd0;
    res_o.byte_valid    = valid;
    res_o.op_done       = done;
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.timeout_flag  = tout;
  end

  // State registers, advanced once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      wait_count_q   <= '0;
      shift_byte_q   <= '0;
      pending_q      <= '0;
      drive_nibble_q <= '0;
      drive_on_q     <= 1'b0;
      strobe_q       <= 1'b1;
      request_q      <= 1'b1;
    end else if (step_i) begin
      phase_q        <= phase_d;
      wait_count_q   <= wait_count_d;
      shift_byte_q   <= shift_byte_d;
      pending_q      <= pending_d;
      drive_nibble_q <= drive_nibble_d;
      drive_on_q     <= drive_on_d;
      strobe_q       <= strobe_d;
      request_q      <= request_d;
    end
  end

  // Checks
  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.byte_valid |-> res_o.op_done)
    else $error("byte_valid without op_done");

  a_tout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.timeout_flag |=> (phase_q == PH_IDLE) && (wait_count_q == '0))
    else $error("timeout did not return to idle");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(wait_count_q))
    else $error("state moved without a tick");

  a_req_nocount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REQ_HI) || (phase_q == PH_REQ_LO) |-> wait_count_q == '0)
    else $error("request wait counted ticks");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (phase_q != PH_IDLE) == $past(res_o.busy_res))
    else $error("busy flag disagrees with phase");

endmodule
